>>> rtl/core/dtt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtt_pkg
// shared types and constants of the deadline timer table
// ----------------------------------------------------------------------------
package dtt_pkg;

   localparam logic [2:0] CMD_ADD     = 3'd0;
   localparam logic [2:0] CMD_CANCEL  = 3'd1;
   localparam logic [2:0] CMD_REFRESH = 3'd2;
   localparam logic [2:0] CMD_RESET   = 3'd3;
   localparam logic [2:0] CMD_EXPIRE  = 3'd4;
   localparam logic [2:0] CMD_QUERY   = 3'd5;

   localparam logic [1:0] STS_OK        = 2'd0;
   localparam logic [1:0] STS_NOT_ARMED = 2'd1;
   localparam logic [1:0] STS_NO_FREE   = 2'd2;

   localparam logic [31:0] DEFAULT_WINDOW_MS = 32'd3600000;
   localparam logic [63:0] NONE_LEFT         = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   typedef struct packed {
      logic period_we;
      logic deadline_we;
   } wr_en_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [3:0]  slot;
      logic [31:0] period_ms;
      logic        repeat_req;
      logic        restart_now;
      logic [47:0] now_ms;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [3:0]  slot_out;
      logic [1:0]  status;
      logic [63:0] remaining_ms;
      logic        front_notice;
      logic        last;
   } rsp_type;

endpackage
`default_nettype wire

>>> rtl/core/dtt_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtt_alu
// shared 64-bit add / subtract unit with unsigned less-than flag
// ----------------------------------------------------------------------------
module dtt_alu (
   input  dtt_pkg::alu_op_type op,
   input  logic [63:0]         a,
   input  logic [63:0]         b,
   output logic [63:0]         res,
   output logic                lt
);

   logic        sub;
   logic [63:0] bb;
   logic [64:0] sum;

   assign sub = (op == dtt_pkg::ALU_SUB);
   assign bb  = sub ? ~b : b;
   assign sum = {1'b0, a} + {1'b0, bb} + {64'b0, sub};
   assign res = sum[63:0];
   // no carry out of a - b means a borrow
   assign lt  = sub && !sum[64];

endmodule
`default_nettype wire

>>> rtl/core/dtt_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtt_store
// period and deadline memories, one write and one registered read port
// ----------------------------------------------------------------------------
module dtt_store #(
   parameter int NUM_SLOTS = 16,
   parameter int SW        = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  dtt_pkg::wr_en_type  wr_en,
   input  logic [SW-1:0]       wr_addr,
   input  logic [31:0]         wr_period,
   input  logic [48:0]         wr_deadline,
   input  logic [SW-1:0]       rd_addr,
   output logic [31:0]         rd_period,
   output logic [48:0]         rd_deadline
);

   logic [31:0]          period_mem [NUM_SLOTS];
   logic [48:0]          deadline_mem [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] pwr_ff;
   logic [31:0]          rd_period_ff;
   logic [48:0]          rd_deadline_ff;

   // unwritten periods read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         pwr_ff <= '0;
      end else if (wr_en.period_we) begin
         pwr_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en.period_we) begin
         period_mem[wr_addr] <= wr_period;
      end
      if (wr_en.deadline_we) begin
         deadline_mem[wr_addr] <= wr_deadline;
      end
      rd_period_ff   <= pwr_ff[rd_addr] ? period_mem[rd_addr] : 32'd0;
      rd_deadline_ff <= deadline_mem[rd_addr];
   end

   assign rd_period   = rd_period_ff;
   assign rd_deadline = rd_deadline_ff;

endmodule
`default_nettype wire

>>> rtl/core/deadline_timer_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// deadline_timer_table
// table of timer slots ordered by (deadline, slot), with expire and query
// ----------------------------------------------------------------------------
// One command is taken at a time; req_stall stays high until its last result
// has been loaded into the output register. Every scan walks the slot memory
// one slot per cycle through a single registered read port, and one shared
// 64-bit add/subtract unit does every time and deadline sum and compare. Cancel
// and undefined commands go straight to the finish step; add, refresh, reset
// and query scan the table first; an expire checks for rollover, runs one scan
// to build its due set, then scans again for each timer it fires and once more
// to find none left. Results can wait on an output stall. No clearing pass
// after reset: unwritten periods read as zero through valid bits.
// ----------------------------------------------------------------------------
module deadline_timer_table #(
   parameter int NUM_SLOTS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dtt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dtt_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [31:0]      csr_data
);

   localparam int SW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CW  = $clog2(NUM_SLOTS + 1);
   localparam int SXW = (SW > 4) ? SW : 4;

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b00_0000_0001,
      ST_SCAN   = 10'b00_0000_0010,
      ST_ROLL_A = 10'b00_0000_0100,
      ST_ROLL_B = 10'b00_0000_1000,
      ST_ROLL_C = 10'b00_0001_0000,
      ST_FIN_A  = 10'b00_0010_0000,
      ST_FIN_B  = 10'b00_0100_0000,
      ST_FIN_C  = 10'b00_1000_0000,
      ST_FIRE   = 10'b01_0000_0000,
      ST_EMIT   = 10'b10_0000_0000
   } state_type;

   // control state
   state_type            state_ff, state_in;
   logic [31:0]          win_ff, win_in;
   logic [47:0]          prev_ff, prev_in;
   logic                 notified_ff, notified_in;
   logic [NUM_SLOTS-1:0] armed_ff, armed_in;
   logic [NUM_SLOTS-1:0] repeat_ff, repeat_in;
   logic                 due_done_ff, due_done_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 pv_ff, pv_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // captured command and scan results
   logic [2:0]           cmd_ff, cmd_in;
   logic [3:0]           slot_ff, slot_in;
   logic [31:0]          per_ff, per_in;
   logic                 rep_ff, rep_in;
   logic                 fn_ff, fn_in;
   logic [47:0]          now_ff, now_in;
   logic [NUM_SLOTS-1:0] due_ff, due_in;
   logic [SW-1:0]        pidx_ff, pidx_in;
   logic                 best_found_ff, best_found_in;
   logic [48:0]          best_d_ff, best_d_in;
   logic [SW-1:0]        best_idx_ff, best_idx_in;
   logic [31:0]          best_p_ff, best_p_in;
   logic                 free_found_ff, free_found_in;
   logic [SW-1:0]        free_idx_ff, free_idx_in;
   logic [31:0]          ps_ff, ps_in;
   logic [48:0]          ds_ff, ds_in;
   logic [63:0]          tmp_ff, tmp_in;
   logic                 flag_ff, flag_in;
   logic [3:0]           rp_slot_ff, rp_slot_in;
   logic [1:0]           rp_status_ff, rp_status_in;
   logic [63:0]          rp_rem_ff, rp_rem_in;
   logic                 rp_front_ff, rp_front_in;
   dtt_pkg::rsp_type     rsp_ff, rsp_in;

   // shared unit and memory port
   dtt_pkg::alu_op_type  alu_op;
   logic [63:0]          alu_a, alu_b, alu_res;
   logic                 alu_lt;
   dtt_pkg::wr_en_type   wr_en;
   logic [SW-1:0]        wr_addr;
   logic [31:0]          wr_period;
   logic [48:0]          wr_deadline;
   logic [SW-1:0]        rd_addr;
   logic [31:0]          rd_period;
   logic [48:0]          rd_deadline;

   logic                 req_fire;
   logic                 out_free;
   logic                 scan_start;
   logic [SXW-1:0]       slot_x;
   logic [SW-1:0]        s_idx;
   logic                 slot_ok;
   logic                 s_armed;
   logic                 due_pass;
   logic                 cand;
   logic                 before_best;
   logic [SW-1:0]        tgt_idx;

   dtt_alu u_alu (
      .op  (alu_op),
      .a   (alu_a),
      .b   (alu_b),
      .res (alu_res),
      .lt  (alu_lt)
   );

   dtt_store #(
      .NUM_SLOTS (NUM_SLOTS),
      .SW        (SW)
   ) u_store (
      .clock       (clock),
      .reset       (reset),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_period   (wr_period),
      .wr_deadline (wr_deadline),
      .rd_addr     (rd_addr),
      .rd_period   (rd_period),
      .rd_deadline (rd_deadline)
   );

   // handshakes
   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // addressed slot, out of range counts as not armed
   assign slot_x  = SXW'(slot_ff);
   assign s_idx   = slot_x[SW-1:0];
   assign slot_ok = (32'(slot_x) < NUM_SLOTS);
   assign s_armed = slot_ok && armed_ff[s_idx];

   // first expire pass builds the due set, later passes pick from it
   assign due_pass = (cmd_ff == dtt_pkg::CMD_EXPIRE) && !due_done_ff;
   assign cand = (cmd_ff == dtt_pkg::CMD_EXPIRE) ? due_ff[pidx_ff] :
                 (armed_ff[pidx_ff] &&
                  !((cmd_ff == dtt_pkg::CMD_RESET) && (pidx_ff == s_idx)));

   // rearmed slot is compared against the best of the others
   assign tgt_idx = (cmd_ff == dtt_pkg::CMD_ADD) ? free_idx_ff : s_idx;
   assign before_best = !best_found_ff || alu_lt ||
                        ((alu_res == 64'd0) && (tgt_idx < best_idx_ff));

   always_comb begin
      state_in      = state_ff;
      win_in        = win_ff;
      prev_in       = prev_ff;
      notified_in   = notified_ff;
      armed_in      = armed_ff;
      repeat_in     = repeat_ff;
      due_done_in   = due_done_ff;
      cnt_in        = cnt_ff;
      pv_in         = pv_ff;
      cmd_in        = cmd_ff;
      slot_in       = slot_ff;
      per_in        = per_ff;
      rep_in        = rep_ff;
      fn_in         = fn_ff;
      now_in        = now_ff;
      due_in        = due_ff;
      pidx_in       = pidx_ff;
      best_found_in = best_found_ff;
      best_d_in     = best_d_ff;
      best_idx_in   = best_idx_ff;
      best_p_in     = best_p_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      ps_in         = ps_ff;
      ds_in         = ds_ff;
      tmp_in        = tmp_ff;
      flag_in       = flag_ff;
      rp_slot_in    = rp_slot_ff;
      rp_status_in  = rp_status_ff;
      rp_rem_in     = rp_rem_ff;
      rp_front_in   = rp_front_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      alu_op        = dtt_pkg::ALU_SUB;
      alu_a         = 64'd0;
      alu_b         = 64'd0;
      wr_en         = '0;
      wr_addr       = s_idx;
      wr_period     = per_ff;
      wr_deadline   = alu_res[48:0];
      rd_addr       = (cnt_ff < CW'(NUM_SLOTS)) ? cnt_ff[SW-1:0] : '0;
      scan_start    = 1'b0;

      if (csr_valid) begin
         win_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in  = req_data.cmd;
               slot_in = req_data.slot;
               per_in  = req_data.period_ms;
               rep_in  = req_data.repeat_req;
               fn_in   = req_data.restart_now;
               now_in  = req_data.now_ms;
               unique case (req_data.cmd)
                  dtt_pkg::CMD_ADD, dtt_pkg::CMD_REFRESH,
                  dtt_pkg::CMD_RESET, dtt_pkg::CMD_QUERY: begin
                     state_in   = ST_SCAN;
                     scan_start = 1'b1;
                  end
                  dtt_pkg::CMD_EXPIRE: begin
                     state_in    = ST_ROLL_A;
                     due_done_in = 1'b0;
                  end
                  default: begin
                     state_in = ST_FIN_A;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // address stage
            if (cnt_ff < CW'(NUM_SLOTS)) begin
               cnt_in  = cnt_ff + CW'(1);
               pv_in   = 1'b1;
               pidx_in = cnt_ff[SW-1:0];
            end else begin
               pv_in = 1'b0;
            end
            // data stage
            if (due_pass) begin
               alu_a = {16'd0, now_ff};
               alu_b = {15'd0, rd_deadline};
            end else begin
               alu_a = {15'd0, rd_deadline};
               alu_b = {15'd0, best_d_ff};
            end
            if (pv_ff) begin
               if (pidx_ff == s_idx) begin
                  ps_in = rd_period;
                  ds_in = rd_deadline;
               end
               if (!armed_ff[pidx_ff] && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = pidx_ff;
               end
               if (due_pass) begin
                  due_in[pidx_ff] = armed_ff[pidx_ff] && (flag_ff || !alu_lt);
               end else if (cand && (!best_found_ff || alu_lt)) begin
                  // ascending slots, so a tie keeps the lower slot
                  best_found_in = 1'b1;
                  best_d_in     = rd_deadline;
                  best_idx_in   = pidx_ff;
                  best_p_in     = rd_period;
               end
               if (pidx_ff == SW'(NUM_SLOTS - 1)) begin
                  if (cmd_ff == dtt_pkg::CMD_EXPIRE) begin
                     if (due_pass) begin
                        due_done_in = 1'b1;
                        scan_start  = 1'b1;
                     end else if (best_found_in) begin
                        state_in = ST_FIRE;
                     end else begin
                        rp_slot_in   = 4'd0;
                        rp_status_in = dtt_pkg::STS_OK;
                        rp_rem_in    = 64'd0;
                        rp_front_in  = 1'b0;
                        state_in     = ST_EMIT;
                     end
                  end else begin
                     state_in = ST_FIN_A;
                  end
               end
            end
         end

         // rollover: prev > window and now < prev - window
         ST_ROLL_A: begin
            alu_a    = {32'd0, win_ff};
            alu_b    = {16'd0, prev_ff};
            flag_in  = alu_lt;
            state_in = ST_ROLL_B;
         end

         ST_ROLL_B: begin
            alu_a    = {16'd0, prev_ff};
            alu_b    = {32'd0, win_ff};
            tmp_in   = alu_res;
            state_in = ST_ROLL_C;
         end

         ST_ROLL_C: begin
            alu_a      = {16'd0, now_ff};
            alu_b      = tmp_ff;
            flag_in    = flag_ff && alu_lt;
            prev_in    = now_ff;
            state_in   = ST_SCAN;
            scan_start = 1'b1;
         end

         ST_FIN_A: begin
            rp_slot_in   = slot_ff;
            rp_status_in = dtt_pkg::STS_OK;
            rp_rem_in    = 64'd0;
            rp_front_in  = 1'b0;
            state_in     = ST_EMIT;
            unique case (cmd_ff)
               dtt_pkg::CMD_ADD: begin
                  rp_slot_in = 4'd0;
                  if (!free_found_ff) begin
                     rp_status_in = dtt_pkg::STS_NO_FREE;
                  end else begin
                     alu_op   = dtt_pkg::ALU_ADD;
                     alu_a    = {16'd0, now_ff};
                     alu_b    = {32'd0, per_ff};
                     tmp_in   = {15'd0, alu_res[48:0]};
                     state_in = ST_FIN_B;
                  end
               end
               dtt_pkg::CMD_CANCEL: begin
                  if (s_armed) begin
                     armed_in[s_idx] = 1'b0;
                  end else begin
                     rp_status_in = dtt_pkg::STS_NOT_ARMED;
                  end
               end
               dtt_pkg::CMD_REFRESH: begin
                  alu_op = dtt_pkg::ALU_ADD;
                  alu_a  = {16'd0, now_ff};
                  alu_b  = {32'd0, ps_ff};
                  if (s_armed) begin
                     wr_en.deadline_we = 1'b1;
                  end else begin
                     rp_status_in = dtt_pkg::STS_NOT_ARMED;
                  end
               end
               dtt_pkg::CMD_RESET: begin
                  alu_a = {15'd0, ds_ff};
                  alu_b = {32'd0, ps_ff};
                  if (slot_ok && (per_ff == ps_ff) && !fn_ff) begin
                     rp_status_in = dtt_pkg::STS_OK;
                  end else if (!s_armed) begin
                     rp_status_in = dtt_pkg::STS_NOT_ARMED;
                  end else begin
                     // start point: now, or deadline minus old period
                     tmp_in   = fn_ff ? {16'd0, now_ff} : {15'd0, alu_res[48:0]};
                     state_in = ST_FIN_B;
                  end
               end
               dtt_pkg::CMD_QUERY: begin
                  rp_slot_in  = 4'd0;
                  notified_in = 1'b0;
                  alu_a       = {15'd0, best_d_ff};
                  alu_b       = {16'd0, now_ff};
                  if (!best_found_ff) begin
                     rp_rem_in = dtt_pkg::NONE_LEFT;
                  end else if (alu_lt || (alu_res == 64'd0)) begin
                     rp_rem_in = 64'd0;
                  end else begin
                     rp_rem_in = alu_res;
                  end
               end
               default: begin
                  rp_slot_in = 4'd0;
               end
            endcase
         end

         ST_FIN_B: begin
            state_in          = ST_FIN_C;
            wr_en.period_we   = 1'b1;
            wr_en.deadline_we = 1'b1;
            if (cmd_ff == dtt_pkg::CMD_ADD) begin
               wr_addr               = free_idx_ff;
               wr_deadline           = tmp_ff[48:0];
               armed_in[free_idx_ff]  = 1'b1;
               repeat_in[free_idx_ff] = rep_ff;
            end else begin
               alu_op      = dtt_pkg::ALU_ADD;
               alu_a       = tmp_ff;
               alu_b       = {32'd0, per_ff};
               wr_deadline = alu_res[48:0];
               tmp_in      = {15'd0, alu_res[48:0]};
            end
         end

         ST_FIN_C: begin
            alu_a        = tmp_ff;
            alu_b        = {15'd0, best_d_ff};
            rp_status_in = dtt_pkg::STS_OK;
            rp_slot_in   = (cmd_ff == dtt_pkg::CMD_ADD) ? 4'(free_idx_ff) : slot_ff;
            rp_front_in  = before_best && !notified_ff;
            if (before_best) begin
               notified_in = 1'b1;
            end
            state_in = ST_EMIT;
         end

         ST_FIRE: begin
            alu_op = dtt_pkg::ALU_ADD;
            alu_a  = {16'd0, now_ff};
            alu_b  = {32'd0, best_p_ff};
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.kind           = 1'b1;
               rsp_in.slot_out       = 4'(best_idx_ff);
               rsp_in.status         = dtt_pkg::STS_OK;
               rsp_in.remaining_ms   = 64'd0;
               rsp_in.front_notice   = 1'b0;
               rsp_in.last           = 1'b0;
               due_in[best_idx_ff]   = 1'b0;
               wr_addr               = best_idx_ff;
               if (repeat_ff[best_idx_ff]) begin
                  wr_en.deadline_we = 1'b1;
               end else begin
                  armed_in[best_idx_ff] = 1'b0;
               end
               state_in   = ST_SCAN;
               scan_start = 1'b1;
            end
         end

         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.kind         = 1'b0;
               rsp_in.slot_out     = rp_slot_ff;
               rsp_in.status       = rp_status_ff;
               rsp_in.remaining_ms = rp_rem_ff;
               rsp_in.front_notice = rp_front_ff;
               rsp_in.last         = 1'b1;
               state_in            = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (scan_start) begin
         cnt_in        = '0;
         pv_in         = 1'b0;
         best_found_in = 1'b0;
         free_found_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         win_ff       <= dtt_pkg::DEFAULT_WINDOW_MS;
         prev_ff      <= 48'd0;
         notified_ff  <= 1'b0;
         armed_ff     <= '0;
         repeat_ff    <= '0;
         due_done_ff  <= 1'b0;
         cnt_ff       <= '0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         win_ff       <= win_in;
         prev_ff      <= prev_in;
         notified_ff  <= notified_in;
         armed_ff     <= armed_in;
         repeat_ff    <= repeat_in;
         due_done_ff  <= due_done_in;
         cnt_ff       <= cnt_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      slot_ff       <= slot_in;
      per_ff        <= per_in;
      rep_ff        <= rep_in;
      fn_ff         <= fn_in;
      now_ff        <= now_in;
      due_ff        <= due_in;
      pidx_ff       <= pidx_in;
      best_found_ff <= best_found_in;
      best_d_ff     <= best_d_in;
      best_idx_ff   <= best_idx_in;
      best_p_ff     <= best_p_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      ps_ff         <= ps_in;
      ds_ff         <= ds_in;
      tmp_ff        <= tmp_in;
      flag_ff       <= flag_in;
      rp_slot_ff    <= rp_slot_in;
      rp_status_ff  <= rp_status_in;
      rp_rem_ff     <= rp_rem_in;
      rp_front_ff   <= rp_front_in;
      rsp_ff        <= rsp_in;
   end

`ifndef SYNTHESIS
   // an accepted command always leaves idle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != ST_IDLE))
      else $error("command accepted but sequencer stayed idle");

   // the memories are never written under a running scan
   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (!wr_en.period_we && !wr_en.deadline_we))
      else $error("memory write during scan");

   // read data in flight always belongs to a real slot
   a_pidx_range: assert property (@(posedge clock) disable iff (reset)
      pv_ff |-> (32'(pidx_ff) < NUM_SLOTS))
      else $error("scan index beyond table");

   // a new transfer is only loaded from a report or reply step
   a_load_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FIRE || $past(state_ff) == ST_EMIT))
      else $error("output loaded outside a result step");
`endif

endmodule
`default_nettype wire

>>> tb/sv/dtt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtt_checker
// watches the command, result and csr channels of the deadline timer table,
// keeps its own copy of the slot table, predicts every result and compares
// ----------------------------------------------------------------------------
module dtt_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  dtt_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  dtt_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic [31:0]      csr_data,
   output int               error_count,
   output int               pending_count
);

   localparam int SLOTS = 16;

   logic [31:0] window_ms;
   logic [31:0] period_tbl [SLOTS];
   logic [48:0] deadline_tbl [SLOTS];
   logic        armed [SLOTS];
   logic        recurring [SLOTS];
   logic        notified;
   logic [47:0] last_scan_time;

   dtt_pkg::rsp_type timer_results[$];

   function automatic dtt_pkg::rsp_type make_rsp(logic kind, logic [3:0] slot,
                                                 logic [1:0] status, logic [63:0] rem,
                                                 logic front);
      dtt_pkg::rsp_type r;
      r.kind = kind;
      r.slot_out = slot;
      r.status = status;
      r.remaining_ms = rem;
      r.front_notice = front;
      r.last = !kind;
      return r;
   endfunction

   // expected results wait in arrival order
   function automatic void queue_result(dtt_pkg::rsp_type r);
      timer_results.insert(timer_results.size(), r);
   endfunction

   // (da, a) ahead of (db, b) in deadline order, lowest slot wins a tie
   function automatic bit ahead(logic [48:0] da, int a, logic [48:0] db, int b);
      return (da < db) || (da == db && a < b);
   endfunction

   // slot s was just armed: notice only if it leads and no notice is pending
   function automatic logic claim_front(int s);
      for (int j = 0; j < SLOTS; j++) begin
         if (j != s && armed[j] && !ahead(deadline_tbl[s], s, deadline_tbl[j], j)) begin
            return 1'b0;
         end
      end
      if (notified) begin
         return 1'b0;
      end
      notified = 1'b1;
      return 1'b1;
   endfunction

   task automatic predict_command(dtt_pkg::req_type r);
      int          s;
      int          best;
      int          free_slot;
      logic        front;
      logic        roll;
      logic        due [SLOTS];
      logic [48:0] start;
      logic [63:0] rem;
      s = r.slot;
      case (r.cmd)
         dtt_pkg::CMD_ADD: begin
            free_slot = SLOTS;
            for (int j = SLOTS - 1; j >= 0; j--) begin
               if (!armed[j]) begin
                  free_slot = j;
               end
            end
            if (free_slot == SLOTS) begin
               queue_result(make_rsp(1'b0, 4'd0, dtt_pkg::STS_NO_FREE, 64'd0, 1'b0));
            end else begin
               period_tbl[free_slot] = r.period_ms;
               deadline_tbl[free_slot] = {1'b0, r.now_ms} + {17'd0, r.period_ms};
               recurring[free_slot] = r.repeat_req;
               armed[free_slot] = 1'b1;
               front = claim_front(free_slot);
               queue_result(make_rsp(1'b0, 4'(free_slot), dtt_pkg::STS_OK, 64'd0, front));
            end
         end
         dtt_pkg::CMD_CANCEL: begin
            if (!armed[s]) begin
               queue_result(make_rsp(1'b0, r.slot, dtt_pkg::STS_NOT_ARMED, 64'd0, 1'b0));
            end else begin
               armed[s] = 1'b0;
               queue_result(make_rsp(1'b0, r.slot, dtt_pkg::STS_OK, 64'd0, 1'b0));
            end
         end
         dtt_pkg::CMD_REFRESH: begin
            if (!armed[s]) begin
               queue_result(make_rsp(1'b0, r.slot, dtt_pkg::STS_NOT_ARMED, 64'd0, 1'b0));
            end else begin
               deadline_tbl[s] = {1'b0, r.now_ms} + {17'd0, period_tbl[s]};
               queue_result(make_rsp(1'b0, r.slot, dtt_pkg::STS_OK, 64'd0, 1'b0));
            end
         end
         dtt_pkg::CMD_RESET: begin
            if (r.period_ms == period_tbl[s] && !r.restart_now) begin
               // same period, old start: nothing changes, armed or not
               queue_result(make_rsp(1'b0, r.slot, dtt_pkg::STS_OK, 64'd0, 1'b0));
            end else if (!armed[s]) begin
               queue_result(make_rsp(1'b0, r.slot, dtt_pkg::STS_NOT_ARMED, 64'd0, 1'b0));
            end else begin
               start = r.restart_now ? {1'b0, r.now_ms} :
                       deadline_tbl[s] - {17'd0, period_tbl[s]};
               period_tbl[s] = r.period_ms;
               deadline_tbl[s] = start + {17'd0, r.period_ms};
               front = claim_front(s);
               queue_result(make_rsp(1'b0, r.slot, dtt_pkg::STS_OK, 64'd0, front));
            end
         end
         dtt_pkg::CMD_EXPIRE: begin
            roll = ({16'd0, last_scan_time} > {32'd0, window_ms}) &&
                   ({16'd0, r.now_ms} < {16'd0, last_scan_time} - {32'd0, window_ms});
            last_scan_time = r.now_ms;
            for (int j = 0; j < SLOTS; j++) begin
               due[j] = armed[j] && (roll || deadline_tbl[j] <= {1'b0, r.now_ms});
            end
            forever begin
               best = SLOTS;
               for (int j = 0; j < SLOTS; j++) begin
                  if (due[j] && (best == SLOTS ||
                      ahead(deadline_tbl[j], j, deadline_tbl[best], best))) begin
                     best = j;
                  end
               end
               if (best == SLOTS) begin
                  break;
               end
               due[best] = 1'b0;
               queue_result(make_rsp(1'b1, 4'(best), dtt_pkg::STS_OK, 64'd0, 1'b0));
               if (recurring[best]) begin
                  deadline_tbl[best] = {1'b0, r.now_ms} + {17'd0, period_tbl[best]};
               end else begin
                  armed[best] = 1'b0;
               end
            end
            queue_result(make_rsp(1'b0, 4'd0, dtt_pkg::STS_OK, 64'd0, 1'b0));
         end
         dtt_pkg::CMD_QUERY: begin
            notified = 1'b0;
            best = SLOTS;
            for (int j = 0; j < SLOTS; j++) begin
               if (armed[j] && (best == SLOTS ||
                   ahead(deadline_tbl[j], j, deadline_tbl[best], best))) begin
                  best = j;
               end
            end
            if (best == SLOTS) begin
               rem = dtt_pkg::NONE_LEFT;
            end else if ({1'b0, r.now_ms} >= deadline_tbl[best]) begin
               rem = 64'd0;
            end else begin
               rem = {15'd0, deadline_tbl[best]} - {16'd0, r.now_ms};
            end
            queue_result(make_rsp(1'b0, 4'd0, dtt_pkg::STS_OK, rem, 1'b0));
         end
         default: begin
            queue_result(make_rsp(1'b0, 4'd0, dtt_pkg::STS_OK, 64'd0, 1'b0));
         end
      endcase
   endtask

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
      error_count++;
   endtask

   initial begin
      error_count = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      dtt_pkg::rsp_type want;
      if (reset) begin
         window_ms = dtt_pkg::DEFAULT_WINDOW_MS;
         for (int j = 0; j < SLOTS; j++) begin
            period_tbl[j] = '0;
            deadline_tbl[j] = '0;
            armed[j] = 1'b0;
            recurring[j] = 1'b0;
         end
         notified = 1'b0;
         last_scan_time = '0;
         timer_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            window_ms = csr_data;
         end
         if (rsp_valid && !rsp_stall) begin
            if (timer_results.size() == 0) begin
               report_mismatch("unexpected transfer, slot_out", rsp_data.slot_out, 64'd0);
            end else begin
               want = timer_results.pop_front();
               if (rsp_data.kind !== want.kind)
                  report_mismatch("kind", rsp_data.kind, want.kind);
               if (rsp_data.slot_out !== want.slot_out)
                  report_mismatch("slot_out", rsp_data.slot_out, want.slot_out);
               if (rsp_data.status !== want.status)
                  report_mismatch("status", rsp_data.status, want.status);
               if (rsp_data.remaining_ms !== want.remaining_ms)
                  report_mismatch("remaining_ms", rsp_data.remaining_ms, want.remaining_ms);
               if (rsp_data.front_notice !== want.front_notice)
                  report_mismatch("front_notice", rsp_data.front_notice, want.front_notice);
               if (rsp_data.last !== want.last)
                  report_mismatch("last", rsp_data.last, want.last);
            end
         end
         if (req_valid && !req_stall) begin
            predict_command(req_data);
         end
      end
      pending_count <= timer_results.size();
   end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives timer commands and window writes into the deadline timer table;
// the checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module tb;

   localparam int STALL_LIMIT = 20000;
   localparam logic [2:0] CMD_UNDEF_6 = 3'd6;
   localparam logic [2:0] CMD_UNDEF_7 = 3'd7;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   dtt_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   dtt_pkg::rsp_type rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   logic [31:0]      csr_data;
   int               error_count;
   int               pending_count;

   // time base that the commands carry
   logic [47:0] wall_ms;
   int          idle_cycles;

   deadline_timer_table #(.NUM_SLOTS(16)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   dtt_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .error_count(error_count), .pending_count(pending_count)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // result side back-pressure: runs of free flow and stall, some long
   always @(posedge clock) begin
      int run;
      if (reset) begin
         run = 0;
         rsp_stall <= 1'b0;
      end else if (run > 0) begin
         run--;
      end else if (rsp_stall) begin
         rsp_stall <= 1'b0;
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 12);
      end else begin
         rsp_stall <= 1'b1;
         run = pick_gap();
      end
   end

   // watchdog: too long with no transfer anywhere ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // one command transfer; the gap comes first so valid is set once per step
   task automatic issue(logic [2:0] cmd, logic [3:0] slot, logic [31:0] period,
                        logic rpt, logic restart, logic [47:0] now);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{cmd: cmd, slot: slot, period_ms: period, repeat_req: rpt,
                    restart_now: restart, now_ms: now};
      do @(posedge clock); while (req_stall);
   endtask

   // window writes only with the table idle: sender holds off until drained
   task automatic write_window(logic [31:0] value);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (8) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] pick_period();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) begin
         case ($urandom_range(0, 2))
            0: return 32'd10;
            1: return 32'd100;
            default: return 32'd1000;
         endcase
      end
      if (r < 80) return $urandom_range(0, 3000);
      if (r < 85) return 32'hFFFF_FFFF;
      return $urandom;
   endfunction

   // time mostly moves forward, sometimes jumps back or anywhere
   task automatic advance_wall();
      int r;
      logic [63:0] wide;
      r = $urandom_range(0, 99);
      if (r < 3) begin
         wall_ms = wall_ms - 48'($urandom_range(0, 20_000_000));
      end else if (r < 5) begin
         wide = {$urandom, $urandom};
         wall_ms = wide[47:0];
      end else begin
         wall_ms = wall_ms + 48'($urandom_range(0, 400));
      end
   endtask

   task automatic random_commands(int count, int add_weight);
      int r;
      logic [2:0] cmd;
      for (int i = 0; i < count; i++) begin
         advance_wall();
         r = $urandom_range(0, 99);
         if (r < add_weight)                cmd = dtt_pkg::CMD_ADD;
         else if (r < add_weight + 10)      cmd = dtt_pkg::CMD_CANCEL;
         else if (r < add_weight + 20)      cmd = dtt_pkg::CMD_REFRESH;
         else if (r < add_weight + 35)      cmd = dtt_pkg::CMD_RESET;
         else if (r < add_weight + 55)      cmd = dtt_pkg::CMD_EXPIRE;
         else if (r < add_weight + 70)      cmd = dtt_pkg::CMD_QUERY;
         else if ($urandom_range(0, 1) == 1) cmd = CMD_UNDEF_6;
         else                                cmd = CMD_UNDEF_7;
         issue(cmd, 4'($urandom_range(0, 15)), pick_period(), 1'($urandom),
               1'($urandom), wall_ms);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      wall_ms = 48'd1000;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, unarmed slots, ties, notices, extremes
      issue(dtt_pkg::CMD_QUERY, 4'd0, 32'd0, 1'b0, 1'b0, wall_ms);
      issue(dtt_pkg::CMD_EXPIRE, 4'd0, 32'd0, 1'b0, 1'b0, wall_ms);
      issue(dtt_pkg::CMD_CANCEL, 4'd3, 32'd0, 1'b0, 1'b0, wall_ms);
      issue(dtt_pkg::CMD_REFRESH, 4'd3, 32'd0, 1'b0, 1'b0, wall_ms);
      issue(dtt_pkg::CMD_RESET, 4'd5, 32'd0, 1'b0, 1'b0, wall_ms);  // same period, untouched slot
      issue(dtt_pkg::CMD_RESET, 4'd5, 32'd7, 1'b0, 1'b1, wall_ms);  // unarmed slot
      issue(dtt_pkg::CMD_ADD, 4'd0, 32'd100, 1'b1, 1'b0, wall_ms);
      issue(dtt_pkg::CMD_ADD, 4'd0, 32'd100, 1'b0, 1'b0, wall_ms);  // equal deadline
      issue(dtt_pkg::CMD_ADD, 4'd0, 32'd50, 1'b0, 1'b0, wall_ms);   // front, already notified
      issue(dtt_pkg::CMD_QUERY, 4'd0, 32'd0, 1'b0, 1'b0, wall_ms);
      issue(dtt_pkg::CMD_ADD, 4'd15, 32'd20, 1'b1, 1'b1, wall_ms);  // new front, notice again
      issue(dtt_pkg::CMD_RESET, 4'd1, 32'd10, 1'b0, 1'b0, wall_ms + 5);
      issue(dtt_pkg::CMD_RESET, 4'd0, 32'd30, 1'b1, 1'b1, wall_ms + 5);
      issue(dtt_pkg::CMD_REFRESH, 4'd2, 32'd0, 1'b0, 1'b0, wall_ms + 8);
      issue(dtt_pkg::CMD_CANCEL, 4'd3, 32'd0, 1'b0, 1'b0, wall_ms + 9);
      issue(CMD_UNDEF_6, 4'hF, 32'hFFFF_FFFF, 1'b1, 1'b1, 48'hFFFF_FFFF_FFFF);
      issue(CMD_UNDEF_7, 4'hA, 32'h5555_5555, 1'b0, 1'b1, wall_ms);
      issue(dtt_pkg::CMD_EXPIRE, 4'd0, 32'd0, 1'b0, 1'b0, wall_ms + 200);
      issue(dtt_pkg::CMD_QUERY, 4'd0, 32'd0, 1'b0, 1'b0, wall_ms + 200);
      issue(dtt_pkg::CMD_ADD, 4'd0, 32'hFFFF_FFFF, 1'b1, 1'b0, 48'hFFFF_FFFF_FFFF);
      issue(dtt_pkg::CMD_EXPIRE, 4'd0, 32'd0, 1'b0, 1'b0, 48'hFFFF_FFFF_FFFF);
      issue(dtt_pkg::CMD_QUERY, 4'd0, 32'd0, 1'b0, 1'b0, 48'hFFFF_FFFF_FFFF);
      issue(dtt_pkg::CMD_EXPIRE, 4'd0, 32'd0, 1'b0, 1'b0, 48'd5);   // big step back: rollover
      issue(dtt_pkg::CMD_QUERY, 4'd0, 32'd0, 1'b0, 1'b0, 48'd5);
      wall_ms = 48'd5;

      // random phases across window settings; add-heavy bursts fill the table
      write_window(32'd0);
      random_commands(70, 25);
      write_window(32'hFFFF_FFFF);
      random_commands(20, 90);
      random_commands(60, 25);
      write_window(32'd5000);
      random_commands(70, 25);
      write_window($urandom);
      random_commands(20, 90);
      random_commands(50, 20);

      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
